>>> design/ssg_pkg.sv
// Shared types and constants of the spindle-synced step generator.
// No dependencies; used by the controller, the datapath and the top level.
package ssg_pkg;

    localparam int AXES            = 6;
    localparam int NREG_AXES       = 6;
    localparam int MAX_STEPS       = 64;
    localparam int RATIO_FRAC_BITS = 16;

    localparam int AXIS_W     = $clog2(NREG_AXES);
    localparam int STEP_CNT_W = $clog2(MAX_STEPS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int POS_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS0      = 3'd2;

    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_FWD     = 2'd1;
    localparam logic [1:0] DIR_REV     = 2'd3;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_INDEX  = 2'd1,
        OP_SAMPLE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WANT_MUL,
        ST_WANT_CLAMP,
        ST_STEP_CHK,
        ST_AX_MUL,
        ST_AX_REF,
        ST_AX_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              arm;
        logic              index;
        logic              sample;
        logic              want_mul;
        logic              want_clamp;
        logic              step_start;
        logic              ax_mul;
        logic              ax_ref;
        logic              ax_cmp;
        logic              emit;
        logic [AXIS_W-1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic sample_go;
        logic step_needed;
        logic at_target;
    } status_t;

endpackage

>>> design/ssg_ctrl.sv
// Sequencing state machine of the step generator.
// Depends on ssg_pkg; drives the datapath through ssg_pkg::cmd_t.
module ssg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  ssg_pkg::status_t  status,
    input  logic              out_free,
    output ssg_pkg::cmd_t     cmd,
    output logic              out_load,
    output logic              out_last
);

    ssg_pkg::state_t                     state_reg, state_next;
    logic [ssg_pkg::STEP_CNT_W-1:0]      n_reg, n_next;
    logic [ssg_pkg::AXIS_W-1:0]          axis_reg, axis_next;
    logic                                fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssg_pkg::ST_IDLE;
            n_reg     <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            axis_reg  <= axis_next;
        end
    end

    // a request is taken only in idle, where ready is high
    assign fire     = in_valid && (state_reg == ssg_pkg::ST_IDLE);
    assign out_last = status.at_target ||
                      (n_reg == ssg_pkg::STEP_CNT_W'(ssg_pkg::MAX_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ssg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (fire)
                begin
                    case (ssg_pkg::op_t'(op))
                        ssg_pkg::OP_ARM:   cmd.arm = 1'b1;
                        ssg_pkg::OP_INDEX: cmd.index = 1'b1;
                        ssg_pkg::OP_SAMPLE:
                        begin
                            if (status.sample_go)
                            begin
                                cmd.sample = 1'b1;
                                n_next     = '0;
                                state_next = ssg_pkg::ST_WANT_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ssg_pkg::ST_WANT_MUL:
            begin
                cmd.want_mul = 1'b1;
                state_next   = ssg_pkg::ST_WANT_CLAMP;
            end
            ssg_pkg::ST_WANT_CLAMP:
            begin
                cmd.want_clamp = 1'b1;
                state_next     = ssg_pkg::ST_STEP_CHK;
            end
            ssg_pkg::ST_STEP_CHK:
            begin
                if (status.step_needed)
                begin
                    cmd.step_start = 1'b1;
                    axis_next      = '0;
                    state_next     = ssg_pkg::ST_AX_MUL;
                end
                else
                begin
                    state_next = ssg_pkg::ST_IDLE;
                end
            end
            ssg_pkg::ST_AX_MUL:
            begin
                cmd.ax_mul = 1'b1;
                state_next = ssg_pkg::ST_AX_REF;
            end
            ssg_pkg::ST_AX_REF:
            begin
                cmd.ax_ref = 1'b1;
                state_next = ssg_pkg::ST_AX_CMP;
            end
            ssg_pkg::ST_AX_CMP:
            begin
                cmd.ax_cmp = 1'b1;
                if (axis_reg == ssg_pkg::AXIS_W'(ssg_pkg::AXES - 1))
                begin
                    state_next = ssg_pkg::ST_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ssg_pkg::ST_AX_MUL;
                end
            end
            ssg_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    out_load = 1'b1;
                    n_next   = n_reg + 1'b1;
                    if (out_last)
                        state_next = ssg_pkg::ST_IDLE;
                    else
                        state_next = ssg_pkg::ST_STEP_CHK;
                end
            end
            default: state_next = ssg_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> design/ssg_dpath.sv
// Datapath of the step generator: registers, tracking state, shared multiplier.
// Depends on ssg_pkg; commanded by ssg_ctrl.
module ssg_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [31:0]              encoder_position,
    input  ssg_pkg::cmd_t                   cmd,
    output ssg_pkg::status_t                status,
    output logic [ssg_pkg::NREG_AXES-1:0]   res_step,
    output logic [ssg_pkg::NREG_AXES-1:0]   res_dir,
    output logic [ssg_pkg::POS_W-1:0]       res_master,
    output logic                            res_done
);

    localparam logic [63:0] HALF_LSB = 64'd1 << (ssg_pkg::RATIO_FRAC_BITS - 1);

    // configuration
    logic [31:0]                 ratio_reg;
    logic [ssg_pkg::POS_W-1:0]   total_reg;
    logic [31:0]                 delta_reg [ssg_pkg::NREG_AXES];

    // tracking state
    logic                        index_seen_reg;
    logic [31:0]                 start_reg;
    logic [1:0]                  dir_reg;
    logic [ssg_pkg::POS_W-1:0]   master_reg;
    logic [31:0]                 emitted_reg [ssg_pkg::NREG_AXES];

    // working registers
    logic [ssg_pkg::POS_W-1:0]   counts_reg;
    logic [ssg_pkg::POS_W-1:0]   wanted_reg;
    logic [ssg_pkg::POS_W-1:0]   next_reg;
    logic                        fwd_reg;
    logic [63:0]                 prod_reg;
    logic [63:0]                 lhs_reg;
    logic [ssg_pkg::NREG_AXES-1:0] smask_reg;
    logic [ssg_pkg::NREG_AXES-1:0] dmask_reg;

    logic [31:0] delta, neg_delta, counts_full, mag, ax_delta, e_adj;
    logic [1:0]  dir_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] rounded, shifted;
    logic        ax_neg, hit;

    assign ax_delta  = delta_reg[cmd.axis];
    assign ax_neg    = ax_delta[31];
    assign mag       = ax_neg ? (32'd0 - ax_delta) : ax_delta;
    assign e_adj     = fwd_reg ? (emitted_reg[cmd.axis] + 32'd1) : emitted_reg[cmd.axis];
    assign hit       = fwd_reg ? (lhs_reg >= prod_reg) : (lhs_reg < prod_reg);

    assign delta     = 32'(encoder_position) - start_reg;
    assign neg_delta = 32'd0 - delta;

    always_comb
    begin
        dir_next = dir_reg;
        if (dir_reg == ssg_pkg::DIR_UNKNOWN && delta != 32'd0)
            dir_next = delta[31] ? ssg_pkg::DIR_REV : ssg_pkg::DIR_FWD;
        case (dir_next)
            ssg_pkg::DIR_FWD: counts_full = delta;
            ssg_pkg::DIR_REV: counts_full = neg_delta;
            default:          counts_full = 32'd0;
        endcase
    end

    always_comb
    begin
        mul_a = {1'b0, counts_reg};
        mul_b = ratio_reg;
        if (cmd.ax_mul)
        begin
            mul_a = {1'b0, next_reg};
            mul_b = mag;
        end
        else if (cmd.ax_ref)
        begin
            mul_a = e_adj;
            mul_b = {1'b0, total_reg};
        end
    end

    assign rounded = prod_reg + HALF_LSB;
    assign shifted = rounded >> ssg_pkg::RATIO_FRAC_BITS;

    assign status.sample_go   = index_seen_reg && (total_reg != '0) && (ratio_reg != '0) &&
                                (master_reg < total_reg);
    assign status.step_needed = (master_reg != wanted_reg);
    assign status.at_target   = (next_reg == wanted_reg);

    assign res_step   = smask_reg;
    assign res_dir    = dmask_reg;
    assign res_master = next_reg;
    assign res_done   = (next_reg == total_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= '0;
            total_reg <= '0;
            for (int i = 0; i < ssg_pkg::NREG_AXES; i++)
                delta_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ssg_pkg::REG_GEAR_RATIO)
                ratio_reg <= cfg_data;
            else if (cfg_index == ssg_pkg::REG_TOTAL)
                total_reg <= cfg_data[ssg_pkg::POS_W-1:0];
            else
                delta_reg[ssg_pkg::AXIS_W'(cfg_index - ssg_pkg::REG_AXIS0)] <= cfg_data;
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_seen_reg <= 1'b0;
            start_reg      <= '0;
            dir_reg        <= ssg_pkg::DIR_UNKNOWN;
            master_reg     <= '0;
            for (int i = 0; i < ssg_pkg::NREG_AXES; i++)
                emitted_reg[i] <= '0;
        end
        else if (cmd.arm)
        begin
            index_seen_reg <= 1'b0;
            start_reg      <= '0;
            dir_reg        <= ssg_pkg::DIR_UNKNOWN;
            master_reg     <= '0;
            for (int i = 0; i < ssg_pkg::NREG_AXES; i++)
                emitted_reg[i] <= '0;
        end
        else
        begin
            if (cmd.index && !index_seen_reg)
            begin
                index_seen_reg <= 1'b1;
                start_reg      <= 32'(encoder_position);
            end
            if (cmd.sample)
                dir_reg <= dir_next;
            if (cmd.ax_cmp && mag != 32'd0 && hit)
            begin
                if (fwd_reg)
                    emitted_reg[cmd.axis] <= emitted_reg[cmd.axis] + 32'd1;
                else
                    emitted_reg[cmd.axis] <= emitted_reg[cmd.axis] - 32'd1;
            end
            if (cmd.emit)
                master_reg <= next_reg;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.sample)
            counts_reg <= counts_full[31] ? '0 : counts_full[ssg_pkg::POS_W-1:0];
        if (cmd.want_mul || cmd.ax_mul || cmd.ax_ref)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (cmd.want_clamp)
            wanted_reg <= (shifted > 64'(total_reg)) ? total_reg : shifted[ssg_pkg::POS_W-1:0];
        if (cmd.step_start)
        begin
            fwd_reg   <= (wanted_reg > master_reg);
            next_reg  <= (wanted_reg > master_reg) ? (master_reg + 1'b1) : (master_reg - 1'b1);
            smask_reg <= '0;
            dmask_reg <= '0;
        end
        if (cmd.ax_ref)
            lhs_reg <= prod_reg + 64'(total_reg >> 1);
        if (cmd.ax_cmp && mag != 32'd0)
        begin
            dmask_reg[cmd.axis] <= fwd_reg ? ax_neg : !ax_neg;
            if (hit)
                smask_reg[cmd.axis] <= 1'b1;
        end
    end

endmodule

>>> design/spindle_synced_step_generator_core.sv
// Top level of the spindle-synced step generator (electronic leadscrew gearing).
// Depends on ssg_pkg, ssg_ctrl and ssg_dpath; holds the result output register.
//
// Usage:
//   Input channel (in_valid/in_ready, op, encoder_position) takes one request
//   at a time: arm a move, an index pulse, or an encoder sample. Arm and index
//   requests finish in the accepting cycle and give no result.
//   A sample forms the wanted master step (a multiply, then a clamp), then
//   walks toward it, giving one result per master step on the output channel
//   (out_valid/out_ready), at most 64 per sample, last marking the final one.
//   For each master step, every axis needs two passes through the one
//   shared 32x32 multiplier plus a compare, one axis after another.
//   The block takes no new request until the walk of a sample ends; the last
//   result may still wait in the output register while a new request enters.
//   When the receiver stalls, the walk holds with its step computed until the
//   output register frees up.
//   Reset clears the configuration registers, the tracking state and the
//   output valid flag; configuration writes (cfg_we) take effect at once.
module spindle_synced_step_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic signed [31:0]              encoder_position,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [5:0]                      step_mask,
    output logic [5:0]                      dir_mask,
    output logic [30:0]                     master_position,
    output logic                            move_done,
    output logic                            last
);

    ssg_pkg::cmd_t    cmd;
    ssg_pkg::status_t status;

    logic                            out_valid_reg;
    logic [5:0]                      step_mask_reg;
    logic [5:0]                      dir_mask_reg;
    logic [30:0]                     master_reg;
    logic                            done_reg;
    logic                            last_reg;

    logic                            out_free;
    logic                            out_load;
    logic                            out_last;
    logic [ssg_pkg::NREG_AXES-1:0]   res_step;
    logic [ssg_pkg::NREG_AXES-1:0]   res_dir;
    logic [ssg_pkg::POS_W-1:0]       res_master;
    logic                            res_done;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    ssg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .out_free (out_free),
        .cmd      (cmd),
        .out_load (out_load),
        .out_last (out_last)
    );

    ssg_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .encoder_position (encoder_position),
        .cmd              (cmd),
        .status           (status),
        .res_step         (res_step),
        .res_dir          (res_dir),
        .res_master       (res_master),
        .res_done         (res_done)
    );

    // hold valid until the receiver takes the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // capture the finished step
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            step_mask_reg <= 6'(res_step);
            dir_mask_reg  <= 6'(res_dir);
            master_reg    <= res_master;
            done_reg      <= res_done;
            last_reg      <= out_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign step_mask       = step_mask_reg;
    assign dir_mask        = dir_mask_reg;
    assign master_position = master_reg;
    assign move_done       = done_reg;
    assign last            = last_reg;

endmodule

>>> verif/tb.sv
// Self-checking bench for spindle_synced_step_generator_core.
// Depends on ssg_pkg and the core; predicts every step result in-line.
module tb;

    localparam int LIMIT_CYCLES = 2000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] pos;
    } request_t;

    typedef struct packed {
        logic [5:0]  smask;
        logic [5:0]  dmask;
        logic [30:0] mpos;
        logic        done;
        logic        lst;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic signed [31:0] encoder_position;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  step_mask;
    logic [5:0]  dir_mask;
    logic [30:0] master_position;
    logic        move_done;
    logic        last;

    spindle_synced_step_generator_core DUT (.*);

    // predictor copy of the registers and the tracking state
    logic [31:0] ratio_r;
    logic [30:0] total_r;
    logic [31:0] axdelta_r [ssg_pkg::NREG_AXES];
    logic        idx_seen;
    logic [31:0] start_pos;
    logic [1:0]  spin_dir;
    logic [31:0] master_cnt;
    logic [31:0] axis_cnt [ssg_pkg::NREG_AXES];

    request_t pending_q [$];
    step_t    expected_steps [$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       requests_sent = 0;
    int       cycle_cnt = 0;
    int       hold_off = 0;
    int       in_gap = 0;
    int       out_gap = 0;
    bit       stim_done = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] d);
        return d[31] ? 32'd0 - d : d;
    endfunction

    // Advance the predictor by one accepted request and queue its results.
    task automatic predict_request(request_t rq);
        logic [31:0] dlt;
        logic [31:0] cnts;
        logic [31:0] nxt;
        logic [31:0] m;
        logic [63:0] want;
        logic [63:0] desired;
        logic [31:0] tot;
        logic        fwd;
        step_t       s;
        int          n;
        n = 0;
        tot = {1'b0, total_r};
        case (ssg_pkg::op_t'(rq.op))
            ssg_pkg::OP_ARM:
            begin
                idx_seen = 0;
                start_pos = 0;
                spin_dir = ssg_pkg::DIR_UNKNOWN;
                master_cnt = 0;
                for (int i = 0; i < ssg_pkg::NREG_AXES; i++)
                    axis_cnt[i] = 0;
            end
            ssg_pkg::OP_INDEX:
            begin
                if (!idx_seen)
                begin
                    idx_seen = 1;
                    start_pos = rq.pos;
                end
            end
            ssg_pkg::OP_SAMPLE:
            begin
                if (idx_seen && tot != 0 && ratio_r != 0 && master_cnt < tot)
                begin
                    dlt = rq.pos - start_pos;
                    if (spin_dir == ssg_pkg::DIR_UNKNOWN && dlt != 0)
                        spin_dir = dlt[31] ? ssg_pkg::DIR_REV : ssg_pkg::DIR_FWD;
                    if (spin_dir == ssg_pkg::DIR_FWD)
                        cnts = dlt;
                    else if (spin_dir == ssg_pkg::DIR_REV)
                        cnts = 32'd0 - dlt;
                    else
                        cnts = 0;
                    if (cnts[31])
                        cnts = 0;
                    want = (64'(cnts) * 64'(ratio_r)
                            + (64'd1 << (ssg_pkg::RATIO_FRAC_BITS - 1)))
                           >> ssg_pkg::RATIO_FRAC_BITS;
                    if (want > 64'(tot))
                        want = 64'(tot);
                    while (n < ssg_pkg::MAX_STEPS && 64'(master_cnt) != want)
                    begin
                        fwd = want > 64'(master_cnt);
                        nxt = fwd ? master_cnt + 1 : master_cnt - 1;
                        s = '0;
                        for (int i = 0; i < ssg_pkg::AXES; i++)
                        begin
                            m = mag32(axdelta_r[i]);
                            if (m != 0)
                            begin
                                if (fwd ? axdelta_r[i][31] : !axdelta_r[i][31])
                                    s.dmask[i] = 1'b1;
                                desired = (64'(nxt) * 64'(m) + 64'(tot >> 1)) / 64'(tot);
                                if (fwd && desired > 64'(axis_cnt[i]))
                                begin
                                    s.smask[i] = 1'b1;
                                    axis_cnt[i]++;
                                end
                                else if (!fwd && desired < 64'(axis_cnt[i]))
                                begin
                                    s.smask[i] = 1'b1;
                                    axis_cnt[i]--;
                                end
                            end
                        end
                        master_cnt = nxt;
                        s.mpos = master_cnt[30:0];
                        s.done = (master_cnt == tot);
                        expected_steps.push_back(s);
                        n++;
                    end
                    if (n > 0)
                        expected_steps[$].lst = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Driver: present queued requests, hold each until accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= ssg_pkg::OP_ARM;
            encoder_position <= '0;
            in_gap <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (in_valid && in_ready)
            begin
                predict_request('{op, encoder_position});
                requests_sent <= requests_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (pending_q.size() > 0)
                begin
                    request_t rq;
                    rq = pending_q.pop_front();
                    in_valid <= 1'b1;
                    op <= rq.op;
                    encoder_position <= rq.pos;
                    in_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the receiver at random and check each step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                step_t got;
                step_t exp_s;
                got = '{step_mask, dir_mask, master_position, move_done, last};
                results_seen <= results_seen + 1;
                if (expected_steps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected step result %h", got);
                end
                else
                begin
                    exp_s = expected_steps.pop_front();
                    if (got !== exp_s)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("step mismatch: exp smask=%h dmask=%h pos=%0d done=%b last=%b"
                                     , exp_s.smask, exp_s.dmask, exp_s.mpos, exp_s.done,
                                     exp_s.lst);
                        if (mismatches <= 10)
                            $display("               got smask=%h dmask=%h pos=%0d done=%b last=%b"
                                     , got.smask, got.dmask, got.mpos, got.done, got.lst);
                    end
                end
            end
            // long hold-off takes priority so the core fills and stalls its input
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off <= hold_off - 1;
            end
            else if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == ssg_pkg::REG_GEAR_RATIO)
            ratio_r = val;
        else if (idx == ssg_pkg::REG_TOTAL)
            total_r = val[30:0];
        else
            axdelta_r[idx - ssg_pkg::REG_AXIS0] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push(ssg_pkg::op_t o, logic [31:0] p);
        pending_q.push_back('{o, p});
    endtask

    // Wait until all requests are accepted, the core is idle and all results drained.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || expected_steps.size() != 0 ||
               !in_ready || out_valid);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_move(logic [31:0] ratio, logic [30:0] tot);
        write_reg(ssg_pkg::REG_GEAR_RATIO, ratio);
        write_reg(ssg_pkg::REG_TOTAL, {1'b0, tot});
        for (int i = 0; i < ssg_pkg::NREG_AXES; i++)
        begin
            int r;
            logic [31:0] d;
            r = $urandom_range(0, 5);
            if (r == 0)
                d = 0;
            else if (r == 1)
                d = {1'b0, tot};
            else if (r == 2)
                d = 32'd0 - {1'b0, tot};
            else if (r == 3)
                d = $urandom;
            else
                d = $urandom_range(0, 2 * tot) - tot;
            write_reg(ssg_pkg::REG_AXIS0 + 3'(i), d);
        end
    endtask

    // Threading move: arm, index (at times a second), a run of samples with random requests mixed in.
    task automatic queue_move(int nsamp);
        logic [31:0] base;
        logic [31:0] p;
        int sgn;
        base = $urandom;
        sgn = $urandom_range(0, 1) ? 1 : -1;
        push(ssg_pkg::OP_ARM, $urandom);
        push(ssg_pkg::OP_INDEX, base);
        if ($urandom_range(0, 3) == 0)
            push(ssg_pkg::OP_INDEX, $urandom);
        p = base;
        for (int k = 0; k < nsamp; k++)
        begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 6)
                p = p + sgn * $urandom_range(0, 40);
            else if (r < 8)
                p = p - sgn * $urandom_range(0, 30);
            else if (r == 8)
                p = $urandom;
            else
                push(ssg_pkg::op_t'($urandom_range(0, 3)), $urandom);
            push(ssg_pkg::OP_SAMPLE, p);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ratio_r = 0;
        total_r = 0;
        idx_seen = 0;
        start_pos = 0;
        spin_dir = ssg_pkg::DIR_UNKNOWN;
        master_cnt = 0;
        for (int i = 0; i < ssg_pkg::NREG_AXES; i++)
        begin
            axdelta_r[i] = 0;
            axis_cnt[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: samples with zero registers, before index, op 3
        push(ssg_pkg::OP_SAMPLE, 32'd100);
        push(ssg_pkg::OP_INDEX, 32'd0);
        push(ssg_pkg::OP_SAMPLE, 32'd50);
        push(ssg_pkg::OP_NONE, 32'hFFFF_FFFF);
        drain();

        // full walk plus clamp at total, extreme deltas
        write_reg(ssg_pkg::REG_GEAR_RATIO, 32'h0001_0000);
        write_reg(ssg_pkg::REG_TOTAL, 32'd40);
        write_reg(ssg_pkg::REG_AXIS0 + 3'd0, 32'h8000_0000);
        write_reg(ssg_pkg::REG_AXIS0 + 3'd1, 32'h7FFF_FFFF);
        write_reg(ssg_pkg::REG_AXIS0 + 3'd2, 32'd0);
        write_reg(ssg_pkg::REG_AXIS0 + 3'd3, 32'hFFFF_FFEC);
        write_reg(ssg_pkg::REG_AXIS0 + 3'd4, 32'd40);
        write_reg(ssg_pkg::REG_AXIS0 + 3'd5, 32'd13);
        push(ssg_pkg::OP_ARM, 32'd0);
        push(ssg_pkg::OP_INDEX, 32'h7FFF_FFF0);
        push(ssg_pkg::OP_SAMPLE, 32'h7FFF_FFF0);
        push(ssg_pkg::OP_SAMPLE, 32'h8000_0010);
        push(ssg_pkg::OP_SAMPLE, 32'h7FFF_FFF8);
        push(ssg_pkg::OP_SAMPLE, 32'h7FFF_FF00);
        push(ssg_pkg::OP_SAMPLE, 32'h8000_0100);
        push(ssg_pkg::OP_SAMPLE, 32'd0);
        drain();

        // reverse spindle, delta wrap, ratio extremes; receiver holds off
        write_reg(ssg_pkg::REG_GEAR_RATIO, 32'hFFFF_FFFF);
        write_reg(ssg_pkg::REG_TOTAL, 32'h7FFF_FFFF);
        push(ssg_pkg::OP_ARM, 32'd0);
        push(ssg_pkg::OP_INDEX, 32'd0);
        push(ssg_pkg::OP_SAMPLE, 32'hFFFF_FFFF);
        push(ssg_pkg::OP_SAMPLE, 32'h8000_0000);
        push(ssg_pkg::OP_ARM, 32'd0);
        push(ssg_pkg::OP_INDEX, 32'd0);
        push(ssg_pkg::OP_SAMPLE, 32'h0000_0001);
        push(ssg_pkg::OP_SAMPLE, 32'h0000_0003);
        hold_off = 300;
        drain();
        write_reg(ssg_pkg::REG_GEAR_RATIO, 32'd1);
        write_reg(ssg_pkg::REG_TOTAL, 32'd3);
        push(ssg_pkg::OP_ARM, 32'd0);
        push(ssg_pkg::OP_INDEX, 32'd5);
        push(ssg_pkg::OP_SAMPLE, 32'h0002_8005);
        drain();

        // Random moves across settings
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [31:0] ratio;
            logic [30:0] tot;
            case (ph % 4)
                0: ratio = $urandom_range(32'h0000_8000, 32'h0004_0000);
                1: ratio = $urandom;
                2: ratio = $urandom_range(1, 32'h0000_4000);
                default: ratio = 32'h0001_0000;
            endcase
            tot = (ph == 5) ? 31'h7FFF_FFFF : 31'($urandom_range(1, 300));
            set_move(ratio, tot);
            queue_move(13);
            if (ph == 3)
                hold_off = 200;
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done || cycle_cnt >= LIMIT_CYCLES);
        if (!stim_done)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** spindle_synced_step_generator_core: FAILED **");
            $finish;
        end
        else
        begin
            $display("%0d requests sent, %0d step results checked, %0d mismatches",
                     requests_sent, results_seen, mismatches);
            if (mismatches == 0)
                $display("** spindle_synced_step_generator_core: PASSED **");
            else
                $display("** spindle_synced_step_generator_core: FAILED **");
            $finish;
        end
    end

endmodule

>>> files.f
design/ssg_pkg.sv
design/ssg_ctrl.sv
design/ssg_dpath.sv
design/spindle_synced_step_generator_core.sv
verif/tb.sv
